// ===== hdl/qmvs_pkg.sv =====
// Shared types, constants and the capacity table for QR mode and version selection.
package qmvs_pkg;

  localparam int unsigned LEN_W = 10;
  localparam int unsigned VER_W = 4;
  localparam int unsigned TABLE_VERSIONS = 10;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2
  } mode_e;

  localparam logic EC_LEVEL_L = 1'b0;
  localparam logic EC_LEVEL_M = 1'b1;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef logic [LEN_W-1:0] cap_t;
  typedef cap_t cap_row_t [TABLE_VERSIONS];

  // Final beat of a payload, handed from the accumulator to the version selector.
  typedef struct packed {
    mode_e            mode;
    logic [LEN_W-1:0] length;
  } fin_t;

  localparam cap_row_t CAP_L_NUM = '{10'd41, 10'd77, 10'd127, 10'd187, 10'd255,
                                     10'd322, 10'd370, 10'd461, 10'd552, 10'd652};
  localparam cap_row_t CAP_L_ALN = '{10'd25, 10'd47, 10'd77, 10'd114, 10'd154,
                                     10'd195, 10'd224, 10'd279, 10'd335, 10'd395};
  localparam cap_row_t CAP_L_BYT = '{10'd17, 10'd32, 10'd53, 10'd78, 10'd106,
                                     10'd134, 10'd154, 10'd192, 10'd230, 10'd271};
  localparam cap_row_t CAP_M_NUM = '{10'd34, 10'd63, 10'd101, 10'd149, 10'd202,
                                     10'd255, 10'd293, 10'd365, 10'd432, 10'd513};
  localparam cap_row_t CAP_M_ALN = '{10'd20, 10'd38, 10'd61, 10'd90, 10'd122,
                                     10'd154, 10'd178, 10'd221, 10'd262, 10'd311};
  localparam cap_row_t CAP_M_BYT = '{10'd14, 10'd26, 10'd42, 10'd62, 10'd84,
                                     10'd106, 10'd122, 10'd152, 10'd180, 10'd213};

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return c inside {["0":"9"], ["A":"Z"], " ", "$", "%", "*", "+", "-", ".", "/", ":"};
  endfunction

  // Capacity row for one level and mode; an unused mode code gives an all-zero row.
  function automatic cap_row_t cap_row(logic lvl, mode_e m);
    cap_row_t row;
    row = '{default: '0};
    case ({lvl, m})
      {EC_LEVEL_L, MODE_NUMERIC}: row = CAP_L_NUM;
      {EC_LEVEL_L, MODE_ALNUM}:   row = CAP_L_ALN;
      {EC_LEVEL_L, MODE_BYTE}:    row = CAP_L_BYT;
      {EC_LEVEL_M, MODE_NUMERIC}: row = CAP_M_NUM;
      {EC_LEVEL_M, MODE_ALNUM}:   row = CAP_M_ALN;
      {EC_LEVEL_M, MODE_BYTE}:    row = CAP_M_BYT;
      default:                    row = '{default: '0};
    endcase
    return row;
  endfunction

endpackage

// ===== hdl/qr_mode_and_version_select_core.sv =====
// Top level of the QR mode and version selector: accumulator and version select stages.
// Throughput: one character beat per cycle while in_stall_o is low, with no gaps between payloads.
// After the last character is accepted, the result beat passes first through the final-beat
// register and then through the result register.
// Stalls back up through those two registers; input stall rises only when both are full.
// Reset (rst_ni low, asynchronous) empties both stages, sets both payload flags, clears the
// count, and sets the error correction level to L.
module qr_mode_and_version_select_core #(
  parameter int unsigned MAX_VERSION = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          last_char_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    data_mode_o,
  output logic [qmvs_pkg::VER_W-1:0]    symbol_version_o,
  output logic                          too_long_o,
  output logic [qmvs_pkg::LEN_W-1:0]    payload_length_o
);
  import qmvs_pkg::*;

  // Final beat of each payload: mode decided from the running flags and the
  // saturated count including the last character.
  logic fin_valid;
  logic fin_stall;
  fin_t fin;

  // The accumulator classifies every character as it arrives. Only the beat
  // that carries the last flag produces a final beat; all others just update
  // the running flags and count.
  qmvs_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .fin_valid_o (fin_valid),
    .fin_stall_i (fin_stall),
    .fin_o       (fin)
  );

  // The version selector holds the level register, compares the count against
  // the capacity row for the level and mode in parallel, and registers the
  // smallest fitting version together with the mode and count.
  qmvs_vsel #(
    .MAX_VERSION (MAX_VERSION)
  ) u_vsel (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .fin_valid_i      (fin_valid),
    .fin_stall_o      (fin_stall),
    .fin_i            (fin),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_mode_o      (data_mode_o),
    .symbol_version_o (symbol_version_o),
    .too_long_o       (too_long_o),
    .payload_length_o (payload_length_o)
  );

endmodule

// ===== hdl/qmvs_accum.sv =====
// Per-character classification flags, saturating count and the final-beat register.
module qmvs_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_code_i,
  input  logic              last_char_i,
  output logic              fin_valid_o,
  input  logic              fin_stall_i,
  output qmvs_pkg::fin_t    fin_o
);
  import qmvs_pkg::*;

  logic             all_digits_q, all_digits_d;
  logic             all_alnum_q, all_alnum_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic             fin_valid_q, fin_valid_d;
  fin_t             fin_q, fin_d;
  logic             in_acc;
  logic             dig_n, aln_n;
  logic [LEN_W-1:0] cnt_n;

  // A stall only backs up when the final-beat register is full and blocked.
  assign in_stall_o = fin_valid_q & fin_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    dig_n = all_digits_q & is_digit(char_code_i);
    aln_n = all_alnum_q & is_alnum(char_code_i);
    cnt_n = (count_q == LEN_MAX) ? count_q : count_q + 1'b1;

    all_digits_d = all_digits_q;
    all_alnum_d  = all_alnum_q;
    count_d      = count_q;
    fin_valid_d  = fin_valid_q & fin_stall_i;
    fin_d        = fin_q;

    if (in_acc) begin
      if (last_char_i) begin
        all_digits_d = 1'b1;
        all_alnum_d  = 1'b1;
        count_d      = '0;
        fin_valid_d  = 1'b1;
        fin_d.length = cnt_n;
        if (dig_n) begin
          fin_d.mode = MODE_NUMERIC;
        end else if (aln_n) begin
          fin_d.mode = MODE_ALNUM;
        end else begin
          fin_d.mode = MODE_BYTE;
        end
      end else begin
        all_digits_d = dig_n;
        all_alnum_d  = aln_n;
        count_d      = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_digits_q <= 1'b1;
      all_alnum_q  <= 1'b1;
      count_q      <= '0;
      fin_valid_q  <= 1'b0;
    end else begin
      all_digits_q <= all_digits_d;
      all_alnum_q  <= all_alnum_d;
      count_q      <= count_d;
      fin_valid_q  <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_char_i) |=> (count_q == '0 && all_digits_q && all_alnum_q && fin_valid_q))
    else $error("payload state not cleared after the last character");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !last_char_i && count_q != LEN_MAX) |=> (count_q == $past(count_q) + 1'b1))
    else $error("character count did not advance");

  a_digit_implies_alnum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_digits_q |-> all_alnum_q)
    else $error("digit flag set without alphanumeric flag");
`endif

endmodule

// ===== hdl/qmvs_vsel.sv =====
// Level register, capacity compares, version priority pick and the result register.
module qmvs_vsel #(
  parameter int unsigned MAX_VERSION = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  input  logic                          fin_valid_i,
  output logic                          fin_stall_o,
  input  qmvs_pkg::fin_t                fin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    data_mode_o,
  output logic [qmvs_pkg::VER_W-1:0]    symbol_version_o,
  output logic                          too_long_o,
  output logic [qmvs_pkg::LEN_W-1:0]    payload_length_o
);
  import qmvs_pkg::*;

  localparam int unsigned NUM_VER = (MAX_VERSION > TABLE_VERSIONS) ? TABLE_VERSIONS
                                                                   : MAX_VERSION;

  logic             ec_level_q;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       mode_q, mode_d;
  logic [VER_W-1:0] ver_q, ver_d;
  logic             too_long_q, too_long_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             fin_acc;
  cap_row_t         row;
  logic [VER_W-1:0] ver_pick;

  assign fin_stall_o = out_valid_q & out_stall_i;
  assign fin_acc     = fin_valid_i & ~fin_stall_o;

  // Independent compares; scanning downward leaves the smallest fitting version.
  always_comb begin
    row      = cap_row(ec_level_q, fin_i.mode);
    ver_pick = '0;
    for (int i = NUM_VER - 1; i >= 0; i--) begin
      if (row[i] >= fin_i.length) begin
        ver_pick = VER_W'(i + 1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    mode_d      = mode_q;
    ver_d       = ver_q;
    too_long_d  = too_long_q;
    len_d       = len_q;
    if (fin_acc) begin
      out_valid_d = 1'b1;
      mode_d      = fin_i.mode;
      ver_d       = ver_pick;
      too_long_d  = (ver_pick == '0);
      len_d       = fin_i.length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_level_q  <= EC_LEVEL_L;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ec_level_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    ver_q      <= ver_d;
    too_long_q <= too_long_d;
    len_q      <= len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign data_mode_o      = mode_q;
  assign symbol_version_o = ver_q;
  assign too_long_o       = too_long_q;
  assign payload_length_o = len_q;

`ifndef ASSERT_OFF
  a_too_long_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (too_long_q == (ver_q == '0)))
    else $error("too-long flag disagrees with version");

  a_version_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ver_q <= VER_W'(NUM_VER)))
    else $error("version above the configured maximum");

  a_saturated_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && len_q == LEN_MAX) |-> too_long_q)
    else $error("saturated count reported as fitting");

  a_fin_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_acc |=> out_valid_q)
    else $error("accepted final beat did not reach the result register");
`endif

endmodule
